// File: hdl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Shared types and constants of the per-source packet rate limiter: table
// geometry, field widths, verdict codes and the transfer and token structs.
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int VERDICT_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] LIMIT_DEFAULT = COUNT_W'(10);

    // Operation codes of an input transfer.
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Verdict codes of a result transfer.
    localparam logic [VERDICT_W-1:0] VERDICT_NEW   = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_KNOWN = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_OVER  = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_TICK  = 3'd4;

    // Payload of an input transfer.
    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] source_addr;
    } in_item_t;

    // Payload of a result transfer.
    typedef struct packed {
        logic                 pass;
        logic [VERDICT_W-1:0] verdict;
        logic [COUNT_W-1:0]   source_count;
    } out_item_t;

    // Search token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               done;
        logic               is_new;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } token_t;

endpackage

`default_nettype wire

// File: hdl/per_source_packet_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// per_source_packet_rate_limiter_top
// Per-source packet admission filter built as a row of table cells through
// which each packet's search token travels one cell per cycle.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                        Payload
//   input    s_valid, s_ready, s_data     in_item_t  (operation, source_addr)
//   result   m_valid, m_ready, m_data     out_item_t (pass, verdict, count)
//   config   cfg_wr_en, cfg_wr_data       max_packets_per_source, 16 bits
//
// A packet's token is registered at launch and walks the TABLE_DEPTH cells;
// its verdict, or a tick's, is held pending, then moves to the result register.
// One item is in work at a time; the next is taken once the finished result
// has moved into the result register, even if that register is still stalled.
// Reset (aresetn, synchronous, active low) empties the table by clearing the
// fill count and sets the limit to 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module per_source_packet_rate_limiter_top
    import psrl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data
);

    token_t           tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0] entries_used;

    // Sequencer, limit register and result register.
    psrl_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .entries_used (entries_used),
        .launch       (tok[0]),
        .ret          (tok[TABLE_DEPTH])
    );

    // Row of table cells, each handing the token to its neighbour.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        psrl_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .slot         (IDX_W'(i)),
            .entries_used (entries_used),
            .tok_in       (tok[i]),
            .tok_out      (tok[i+1])
        );
    end

endmodule

`default_nettype wire

// File: hdl/psrl_cell.sv
// ----------------------------------------------------------------------------
// psrl_cell
// One table entry. Compares the passing token with its stored source, updates
// its count on a hit, takes the source when it is the append slot, and hands
// the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_cell
    import psrl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] slot,
    input  wire logic [IDX_W-1:0] entries_used,
    input  wire token_t           tok_in,
    output token_t                tok_out
);

    logic [ADDR_W-1:0]  entry_addr_reg;
    logic [COUNT_W-1:0] entry_count_reg;
    token_t             tok_reg;
    token_t             tok_next;

    logic               in_range;
    logic               append_here;
    logic               searching;
    logic               hit;
    logic               take;
    logic [COUNT_W-1:0] count_inc;

    // Hit and append decisions for the token now at this cell.
    always_comb begin
        in_range    = slot < entries_used;
        append_here = slot == entries_used;
        searching   = tok_in.valid && !tok_in.done;
        hit         = searching && in_range && (entry_addr_reg == tok_in.addr);
        take        = searching && append_here;
        count_inc   = (entry_count_reg == COUNT_MAX) ? entry_count_reg
                                                     : entry_count_reg + 1'b1;
        tok_next    = tok_in;
        if (hit) begin
            tok_next.done   = 1'b1;
            tok_next.is_new = 1'b0;
            tok_next.count  = count_inc;
        end else if (take) begin
            tok_next.done   = 1'b1;
            tok_next.is_new = 1'b1;
            tok_next.count  = COUNT_W'(1);
        end
    end

    // Entry storage: written on a hit or when the source is appended here.
    always_ff @(posedge aclk) begin
        if (hit) begin
            entry_count_reg <= count_inc;
        end else if (take) begin
            entry_addr_reg  <= tok_in.addr;
            entry_count_reg <= COUNT_W'(1);
        end
    end

    // Token stage towards the next cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hdl/psrl_ctrl.sv
// ----------------------------------------------------------------------------
// psrl_ctrl
// Control of the rate limiter: input and result handshakes, the limit
// register, the fill count of the table, token launch and the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_ctrl
    import psrl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    output logic [IDX_W-1:0]        entries_used,
    output token_t                  launch,
    input  wire token_t             ret
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } state_t;

    state_t             state_reg,     state_next;
    logic [COUNT_W-1:0] limit_reg,     limit_next;
    logic [IDX_W-1:0]   used_reg,      used_next;
    token_t             launch_reg,    launch_next;
    out_item_t          pend_reg,      pend_next;
    out_item_t          out_reg,       out_next;
    logic               out_valid_reg, out_valid_next;

    logic               accept;
    logic               out_load;
    out_item_t          verdict_item;

    assign accept = s_valid && s_ready;

    // Verdict for a token returning from the end of the row.
    always_comb begin
        verdict_item = '0;
        if (!ret.done) begin
            verdict_item.verdict = VERDICT_FULL;
        end else if (ret.is_new) begin
            verdict_item.pass         = 1'b1;
            verdict_item.verdict      = VERDICT_NEW;
            verdict_item.source_count = ret.count;
        end else if (ret.count <= limit_reg) begin
            verdict_item.pass         = 1'b1;
            verdict_item.verdict      = VERDICT_KNOWN;
            verdict_item.source_count = ret.count;
        end else begin
            verdict_item.verdict      = VERDICT_OVER;
            verdict_item.source_count = ret.count;
        end
    end

    // Sequencer and result register.
    always_comb begin
        state_next     = state_reg;
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
        used_next      = used_reg;
        launch_next    = launch_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        launch_next.valid  = 1'b0;
        launch_next.done   = 1'b0;
        launch_next.is_new = 1'b0;
        launch_next.count  = '0;

        out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.operation == OP_TICK) begin
                        used_next                = '0;
                        pend_next.pass           = 1'b0;
                        pend_next.verdict        = VERDICT_TICK;
                        pend_next.source_count   = '0;
                        state_next               = ST_DONE;
                    end else begin
                        launch_next.valid = 1'b1;
                        launch_next.addr  = s_data.source_addr;
                        state_next        = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (ret.valid) begin
                    pend_next = verdict_item;
                    if (ret.done && ret.is_new) begin
                        used_next = used_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The result register empties on a transfer and refills from the
        // pending result when the sequencer hands it over.
        if (out_load) begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            limit_reg        <= LIMIT_DEFAULT;
            used_reg         <= '0;
            launch_reg.valid <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            used_reg      <= used_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payloads need no reset.
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_data       = out_reg;
    assign entries_used = used_reg;
    assign launch       = launch_reg;

endmodule

`default_nettype wire

// File: hdl/psrl_checker.sv
// ----------------------------------------------------------------------------
// psrl_checker
// Port-level checks of the rate limiter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_checker
    import psrl_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A stalled result transfer holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Every accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // A tick result never admits and carries no count.
    a_tick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict == VERDICT_TICK)
            |-> !m_data.pass && (m_data.source_count == '0))
        else $error("malformed tick result");

    // Admission goes with a passing verdict and a non-zero count.
    a_pass_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pass
            |-> (m_data.verdict == VERDICT_NEW || m_data.verdict == VERDICT_KNOWN)
                && (m_data.source_count != '0))
        else $error("pass without passing verdict");

    // A new source is always reported with a count of one.
    a_new_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.verdict == VERDICT_NEW)
            |-> m_data.pass && (m_data.source_count == COUNT_W'(1)))
        else $error("new source with wrong count");

endmodule

bind per_source_packet_rate_limiter_top psrl_checker u_psrl_checker (.*);

`default_nettype wire
